// ===== hw/rtl/rope_pkg.sv =====
// rope_pkg: shared types, constants and constant tables for the rotary
// position embedding block. No dependencies.
package rope_pkg;

	localparam int DATA_W      = 16;
	localparam int POS_W       = 16;
	localparam int PAIR_W      = 7;
	localparam int BASE_W      = 20;
	localparam int HD_W        = 9;
	localparam int CFG_W       = 20;
	localparam int FREQ_W      = 31;
	localparam int FRAC_BITS   = 28;
	localparam int EXP_W       = 40;
	localparam int DIV_NUM_W   = 61;
	localparam int DIV_DEN_W   = 31;
	localparam int ANG_W       = 33;
	localparam int CX_W        = 33;
	localparam int CZ_W        = 20;
	localparam int CORDIC_STEPS = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic cfg_idx_t;
	localparam cfg_idx_t CFG_FREQ_BASE = 1'b0;
	localparam cfg_idx_t CFG_HEAD_DIM  = 1'b1;

	localparam logic [BASE_W-1:0] BASE_RESET = 20'd10000;
	localparam logic [HD_W-1:0]   HD_RESET   = 9'd128;

	localparam logic [34:0] TWO_PI_Q30   = 35'd6746518852;
	localparam logic [34:0] FOUR_PI_Q30  = 35'd13493037704;
	localparam logic signed [ANG_W-1:0] PI_Q28      = 33'sd843314857;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 33'sd421657428;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 33'sd1686629713;
	localparam logic signed [CX_W-1:0]  CORDIC_GAIN = 33'sd652032874;

	// arctan(2^-i) in Q.16, index i
	localparam logic [CORDIC_STEPS-1:0][16:0] ATAN_Q16 = {
		17'd1, 17'd2, 17'd4, 17'd8, 17'd16, 17'd32, 17'd64, 17'd128, 17'd256,
		17'd512, 17'd1024, 17'd2047, 17'd4091, 17'd8150, 17'd16055, 17'd30386,
		17'd51472
	};

	typedef struct packed {
		logic [POS_W-1:0]         position;
		logic [PAIR_W-1:0]        pair_index;
		logic signed [DATA_W-1:0] first_value;
		logic signed [DATA_W-1:0] second_value;
	} rope_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rotated_first;
		logic signed [DATA_W-1:0] rotated_second;
		logic                     saturated;
	} rope_out_t;

	// one queued item: position, looked-up frequency and the pair
	typedef struct packed {
		logic [POS_W-1:0]         position;
		logic [FREQ_W-1:0]        freq;
		logic signed [DATA_W-1:0] first_value;
		logic signed [DATA_W-1:0] second_value;
	} rope_job_t;

	typedef struct packed {
		logic              we;
		logic [PAIR_W-1:0] addr;
		logic [FREQ_W-1:0] data;
	} rope_tbl_wr_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		x = v;
		for (int k = 0; k < 32; k++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-(i+1)) in Q.30, each the truncated root of the one before
	function automatic logic [FRAC_BITS-1:0][FREQ_W-1:0] root_table();
		logic [63:0] root;
		logic [FRAC_BITS-1:0][FREQ_W-1:0] t;
		root = 64'd2 << 30;
		for (int i = 0; i < FRAC_BITS; i++) begin
			root = isqrt64(root << 30);
			t[i] = root[FREQ_W-1:0];
		end
		return t;
	endfunction

endpackage

// ===== hw/rtl/rotary_position_embedding.sv =====
// Rotary position embedding of one element pair.
// Depends on rope_pkg, rope_setup, rope_front and rope_back.
//
// Input channel item_valid/item_ready/item carries position, pair index and
// the two Q7.8 elements; output channel result_valid/result_ready/result
// carries the rotated pair and a saturation flag, one result per item, in
// order. cfg_we/cfg_index/cfg_data write the frequency base (index 0) or
// head_dim (index 1).
// After reset and after every configuration write the block rebuilds its
// 128-entry frequency table, one entry per pair index; each entry is built
// on the shared serial divider and the exp2 multiplier, after one log2 of
// the base, and ends with a table write. item_ready is low while it runs.
// Throughput is one item per cycle while no rebuild runs and the receiver
// takes the results. From acceptance to result_valid an item passes table
// lookup, queue, 16 stages of modular multiply for the angle, 17 CORDIC
// stages, the product stage and the output register.
// When the receiver stalls the back pipeline holds; the four-entry queue
// keeps taking items until it fills, then item_ready drops.
module rotary_position_embedding #(
	parameter int MAX_HEAD_DIM = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  rope_pkg::rope_in_t         item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output rope_pkg::rope_out_t        result,
	input  logic                       cfg_we,
	input  rope_pkg::cfg_idx_t         cfg_index,
	input  logic [rope_pkg::CFG_W-1:0] cfg_data
);
	import rope_pkg::*;

	logic         setup_busy;
	rope_tbl_wr_t tbl_wr;
	logic         job_valid;
	rope_job_t    job;
	logic         job_pop;

	rope_setup #(.MAX_HEAD_DIM(MAX_HEAD_DIM)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (setup_busy),
		.tbl_wr    (tbl_wr)
	);

	rope_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.setup_busy (setup_busy),
		.tbl_wr     (tbl_wr),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop)
	);

	rope_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== hw/rtl/rope_div.sv =====
// rope_div: restoring divider, one quotient bit per cycle.
// Depends on rope_pkg.
module rope_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rope_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [rope_pkg::DIV_DEN_W-1:0] divisor,
	output logic                           done,
	output logic [rope_pkg::DIV_NUM_W-1:0] quotient
);
	import rope_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 take;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], take};
			rem_q <= take ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ===== hw/rtl/rope_setup.sv =====
// rope_setup: configuration registers and the sequencer that builds the
// per-pair frequency table (log2, exponent divide, exp2, reciprocal).
// Depends on rope_pkg and rope_div.
module rope_setup #(
	parameter int MAX_HEAD_DIM = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  rope_pkg::cfg_idx_t          cfg_index,
	input  logic [rope_pkg::CFG_W-1:0]  cfg_data,
	output logic                        busy,
	output rope_pkg::rope_tbl_wr_t      tbl_wr
);
	import rope_pkg::*;

	localparam int MAXW = $clog2(MAX_HEAD_DIM + 1);
	localparam int HDX_W = (MAXW > HD_W) ? MAXW : HD_W;
	localparam logic [FRAC_BITS-1:0][FREQ_W-1:0] ROOTS = root_table();
	localparam int LOG_W = 5 + FRAC_BITS;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_START     = 3'd1;
	localparam logic [2:0] ST_LOG       = 3'd2;
	localparam logic [2:0] ST_EDIV_GO   = 3'd3;
	localparam logic [2:0] ST_EDIV_WAIT = 3'd4;
	localparam logic [2:0] ST_EXP       = 3'd5;
	localparam logic [2:0] ST_IDIV_GO   = 3'd6;
	localparam logic [2:0] ST_IDIV_WAIT = 3'd7;

	logic [2:0]           state_q;
	logic [BASE_W-1:0]    base_q;
	logic [HD_W-1:0]      hd_q;
	logic [4:0]           step_q;
	logic [4:0]           n_q;
	logic                 small_q;
	logic [31:0]          m_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [PAIR_W-1:0]    j_q;
	logic [11:0]          eint_q;
	logic [FRAC_BITS-1:0] ef_q;
	logic [FREQ_W-1:0]    prod_q;
	logic                 wr_we_q;
	logic [PAIR_W-1:0]    wr_addr_q;
	logic [FREQ_W-1:0]    wr_data_q;

	logic [4:0]           lead;
	logic [HDX_W-1:0]     hd_eff;
	logic [HDX_W-2:0]     half;
	logic [63:0]          sq;
	logic [31:0]          msq;
	logic [61:0]          pr;
	logic [LOG_W-1:0]     lval;
	logic [EXP_W-1:0]     lj;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;

	always_comb begin
		lead = '0;
		for (int b = 0; b < BASE_W; b++) begin
			if (base_q[b])
				lead = 5'(b);
		end
	end

	always_comb begin
		hd_eff = HDX_W'(hd_q);
		if (hd_eff < HDX_W'(2))
			hd_eff = HDX_W'(2);
		if (hd_eff > HDX_W'(MAX_HEAD_DIM))
			hd_eff = HDX_W'(MAX_HEAD_DIM);
	end
	assign half = hd_eff[HDX_W-1:1];

	assign sq   = 64'(m_q) * 64'(m_q);
	assign msq  = sq[61:30];
	assign pr   = 62'(prod_q) * 62'(ROOTS[step_q]);
	assign lval = small_q ? '0 : {n_q, frac_q};
	assign lj   = EXP_W'(lval) * EXP_W'(j_q);

	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_NUM_W'(lj);
		div_den   = DIV_DEN_W'(half);
		unique case (state_q)
			ST_EDIV_GO: div_start = 1'b1;
			ST_IDIV_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'(1) << 60;
				div_den   = prod_q;
			end
			default: ;
		endcase
	end

	rope_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			base_q  <= BASE_RESET;
			hd_q    <= HD_RESET;
			wr_we_q <= 1'b0;
			step_q  <= '0;
			j_q     <= '0;
		end else begin
			wr_we_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FREQ_BASE: base_q <= cfg_data[BASE_W-1:0];
					CFG_HEAD_DIM:  hd_q   <= cfg_data[HD_W-1:0];
				endcase
				state_q <= ST_START;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_START: begin
						step_q  <= '0;
						j_q     <= '0;
						state_q <= ST_LOG;
					end
					ST_LOG: begin
						step_q <= step_q + 1'b1;
						if (step_q == 5'(FRAC_BITS - 1))
							state_q <= ST_EDIV_GO;
					end
					ST_EDIV_GO: state_q <= ST_EDIV_WAIT;
					ST_EDIV_WAIT: begin
						if (div_done) begin
							step_q  <= '0;
							state_q <= ST_EXP;
						end
					end
					ST_EXP: begin
						step_q <= step_q + 1'b1;
						if (step_q == 5'(FRAC_BITS - 1))
							state_q <= ST_IDIV_GO;
					end
					ST_IDIV_GO: state_q <= ST_IDIV_WAIT;
					ST_IDIV_WAIT: begin
						if (div_done) begin
							wr_we_q <= 1'b1;
							j_q     <= j_q + 1'b1;
							state_q <= (&j_q) ? ST_IDLE : ST_EDIV_GO;
						end
					end
				endcase
			end
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_START: begin
				n_q     <= lead;
				small_q <= base_q < BASE_W'(2);
				m_q     <= 32'(base_q) << (5'd30 - lead);
				frac_q  <= '0;
			end
			ST_LOG: begin
				if (msq[31]) begin
					m_q    <= msq >> 1;
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q    <= msq;
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			ST_EDIV_WAIT: begin
				eint_q <= div_quot[EXP_W-1:FRAC_BITS];
				ef_q   <= div_quot[FRAC_BITS-1:0];
				prod_q <= FREQ_W'(1) << 30;
			end
			ST_EXP: begin
				if (ef_q[FRAC_BITS-1])
					prod_q <= pr[60:30];
				ef_q <= ef_q << 1;
			end
			ST_IDIV_WAIT: begin
				wr_addr_q <= j_q;
				wr_data_q <= (eint_q > 12'd30) ? '0 : FREQ_W'(div_quot >> eint_q[4:0]);
			end
			default: ;
		endcase
	end

	// stay busy until the last table entry has landed
	assign busy   = (state_q != ST_IDLE) || wr_we_q;
	assign tbl_wr = '{we: wr_we_q, addr: wr_addr_q, data: wr_data_q};

endmodule

// ===== hw/rtl/rope_front.sv =====
// rope_front: input handshake, frequency table lookup and the item queue
// that feeds the back end. Depends on rope_pkg.
module rope_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  rope_pkg::rope_in_t     item,
	input  logic                   setup_busy,
	input  rope_pkg::rope_tbl_wr_t tbl_wr,
	output logic                   job_valid,
	output rope_pkg::rope_job_t    job,
	input  logic                   job_pop
);
	import rope_pkg::*;

	logic [FREQ_W-1:0] freq_mem [1 << PAIR_W];
	rope_job_t         q_mem [QUEUE_DEPTH];

	logic              valid_s1;
	rope_in_t          item_s1;
	logic [FREQ_W-1:0] freq_s1;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              accept;
	logic              push;
	logic              pop;
	rope_job_t         job_s1;

	// room is counted for the item still at the lookup stage
	assign item_ready = !setup_busy &&
		(QCNT_W'(count_q + QCNT_W'(valid_s1)) < QCNT_W'(QUEUE_DEPTH));
	assign accept = item_valid && item_ready;
	assign push   = valid_s1;
	assign pop    = job_pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (tbl_wr.we)
			freq_mem[tbl_wr.addr] <= tbl_wr.data;
		if (accept) begin
			freq_s1 <= freq_mem[item.pair_index];
			item_s1 <= item;
		end
	end

	assign job_s1 = '{position: item_s1.position, freq: freq_s1,
		first_value: item_s1.first_value, second_value: item_s1.second_value};

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= job_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			valid_s1 <= accept;
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign job_valid = count_q != '0;
	assign job       = q_mem[rd_ptr_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count past depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != QCNT_W'(QUEUE_DEPTH))
		else $error("push into full queue");
	a_lookup_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && push)
		else $error("accepted item lost at lookup");

endmodule

// ===== hw/rtl/rope_back.sv =====
// rope_back: angle reduction, fold, CORDIC and rotate/saturate pipeline
// with the output register. Depends on rope_pkg.
module rope_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  rope_pkg::rope_job_t job,
	output logic                job_pop,
	output logic                result_valid,
	input  logic                result_ready,
	output rope_pkg::rope_out_t result
);
	import rope_pkg::*;

	localparam int MS = POS_W;
	localparam int CS = CORDIC_STEPS;

	logic en;

	// modular multiply stages: acc = (2*acc + bit*freq) mod 2pi, MSB first
	logic [MS:0]              mv_q;
	logic [POS_W-1:0]         mpos_q [MS+1];
	logic [FREQ_W-1:0]        mfreq_q [MS+1];
	logic [ANG_W-1:0]         macc_q [MS+1];
	logic signed [DATA_W-1:0] ma_q [MS+1];
	logic signed [DATA_W-1:0] mb_q [MS+1];

	// CORDIC stages
	logic [CS:0]              cv_q;
	logic signed [CX_W-1:0]   cx_q [CS+1];
	logic signed [CX_W-1:0]   cy_q [CS+1];
	logic signed [CZ_W-1:0]   cz_q [CS+1];
	logic [CS:0]              cneg_q;
	logic signed [DATA_W-1:0] ca_q [CS+1];
	logic signed [DATA_W-1:0] cb_q [CS+1];

	logic                     pv_s1;
	logic signed [48:0]       p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;
	logic                     out_valid_q;
	rope_out_t                out_q;

	assign en      = !out_valid_q || result_ready;
	assign job_pop = en && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q        <= '0;
			cv_q        <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			mv_q        <= {mv_q[MS-1:0], job_valid};
			cv_q        <= {cv_q[CS-1:0], mv_q[MS]};
			pv_s1       <= cv_q[CS];
			out_valid_q <= pv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mpos_q[0]  <= job.position;
			mfreq_q[0] <= job.freq;
			macc_q[0]  <= '0;
			ma_q[0]    <= job.first_value;
			mb_q[0]    <= job.second_value;
		end
	end

	for (genvar k = 0; k < MS; k++) begin : g_mod
		logic [34:0] t;
		assign t = {1'b0, macc_q[k], 1'b0} +
			(mpos_q[k][POS_W-1] ? 35'(mfreq_q[k]) : 35'd0);
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= FOUR_PI_Q30)
					macc_q[k+1] <= ANG_W'(t - FOUR_PI_Q30);
				else if (t >= TWO_PI_Q30)
					macc_q[k+1] <= ANG_W'(t - TWO_PI_Q30);
				else
					macc_q[k+1] <= ANG_W'(t);
				mpos_q[k+1]  <= mpos_q[k] << 1;
				mfreq_q[k+1] <= mfreq_q[k];
				ma_q[k+1]    <= ma_q[k];
				mb_q[k+1]    <= mb_q[k];
			end
		end
	end

	// map to [-pi, pi), fold into [-pi/2, pi/2], drop to Q.16
	logic signed [ANG_W-1:0] z0, z1, z2;
	logic                    fneg;
	always_comb begin
		z0   = ANG_W'(macc_q[MS] >> 2);
		z1   = (z0 >= PI_Q28) ? z0 - TWO_PI_Q28 : z0;
		fneg = 1'b0;
		z2   = z1;
		if (z1 > HALF_PI_Q28) begin
			z2   = z1 - PI_Q28;
			fneg = 1'b1;
		end else if (z1 < -HALF_PI_Q28) begin
			z2   = z1 + PI_Q28;
			fneg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0]   <= CORDIC_GAIN;
			cy_q[0]   <= '0;
			cz_q[0]   <= CZ_W'(z2 >>> 12);
			cneg_q[0] <= fneg;
			ca_q[0]   <= ma_q[MS];
			cb_q[0]   <= mb_q[MS];
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		logic signed [CX_W-1:0] dx, dy;
		logic signed [CZ_W-1:0] at;
		assign dx = cy_q[i] >>> i;
		assign dy = cx_q[i] >>> i;
		assign at = CZ_W'(ATAN_Q16[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_q[i] >= 0) begin
					cx_q[i+1] <= cx_q[i] - dx;
					cy_q[i+1] <= cy_q[i] + dy;
					cz_q[i+1] <= cz_q[i] - at;
				end else begin
					cx_q[i+1] <= cx_q[i] + dx;
					cy_q[i+1] <= cy_q[i] - dy;
					cz_q[i+1] <= cz_q[i] + at;
				end
				cneg_q[i+1] <= cneg_q[i];
				ca_q[i+1]   <= ca_q[i];
				cb_q[i+1]   <= cb_q[i];
			end
		end
	end

	logic signed [CX_W-1:0] cosv, sinv;
	assign cosv = cneg_q[CS] ? -cx_q[CS] : cx_q[CS];
	assign sinv = cneg_q[CS] ? -cy_q[CS] : cy_q[CS];

	always_ff @(posedge clk) begin
		if (en) begin
			p_ac_s1 <= 49'(ca_q[CS]) * 49'(cosv);
			p_bs_s1 <= 49'(cb_q[CS]) * 49'(sinv);
			p_as_s1 <= 49'(ca_q[CS]) * 49'(sinv);
			p_bc_s1 <= 49'(cb_q[CS]) * 49'(cosv);
		end
	end

	// round half up at bit 30, then clip
	localparam logic signed [49:0] RND = 50'sd536870912;
	localparam logic signed [19:0] HI  = 20'sd32767;
	localparam logic signed [19:0] LO  = -20'sd32768;
	logic signed [49:0] s1, s2;
	logic signed [19:0] r1, r2;
	logic               sat1, sat2;
	always_comb begin
		s1   = 50'(p_ac_s1) - 50'(p_bs_s1) + RND;
		s2   = 50'(p_as_s1) + 50'(p_bc_s1) + RND;
		r1   = 20'(s1 >>> 30);
		r2   = 20'(s2 >>> 30);
		sat1 = (r1 > HI) || (r1 < LO);
		sat2 = (r2 > HI) || (r2 < LO);
		if (r1 > HI)
			r1 = HI;
		else if (r1 < LO)
			r1 = LO;
		if (r2 > HI)
			r2 = HI;
		else if (r2 < LO)
			r2 = LO;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.rotated_first  <= r1[DATA_W-1:0];
			out_q.rotated_second <= r2[DATA_W-1:0];
			out_q.saturated      <= sat1 || sat2;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
